### hw/rtl/comb_enum_pkg.sv
// Shared types and constants of the combination enumerator.
`default_nettype none

package comb_enum_pkg;

  // Field and register widths
  localparam int N_W     = 7;   // total_objects register
  localparam int K_W     = 5;   // chosen_count register
  localparam int ELEM_W  = 6;   // element_value port
  localparam int POS_W   = 4;   // position port
  localparam int VAL_W   = 7;   // stored index, holds up to 2**N_W - 2
  localparam int CFG_W   = 7;   // widest register
  localparam int IDX_W   = 1;   // register index

  // Defaults of the top level parameters
  localparam int DEF_MAX_OBJECTS = 64;
  localparam int DEF_MAX_CHOSEN  = 16;

  // Reset values of the registers
  localparam logic [N_W-1:0] RESET_TOTAL  = 7'd4;
  localparam logic [K_W-1:0] RESET_CHOSEN = 5'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TOTAL_OBJECTS = 1'b0;
  localparam logic [IDX_W-1:0] REG_CHOSEN_COUNT  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic report_bad;   // send one bad_config word
    logic report_fin;   // mark the series exhausted and send one finished word
    logic issue;        // read the choice at the current position and advance
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;          // configuration unusable
    logic series_done;  // no further combination remains
    logic issue_last;   // current position is the last of the combination
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/comb_enum_dp.sv
// Datapath: registers, choice memory, pivot tracking and result words.
`default_nettype none

module comb_enum_dp #(
  parameter int MAX_OBJECTS = comb_enum_pkg::DEF_MAX_OBJECTS,
  parameter int MAX_CHOSEN  = comb_enum_pkg::DEF_MAX_CHOSEN
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [comb_enum_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [comb_enum_pkg::CFG_W-1:0]  cfg_data,
  input  wire comb_enum_pkg::cmd_t              cmd,
  output comb_enum_pkg::status_t                st,
  output logic                                  strobe,
  output logic [comb_enum_pkg::ELEM_W-1:0]      element_value,
  output logic [comb_enum_pkg::POS_W-1:0]       position,
  output logic                                  last_element,
  output logic                                  finished,
  output logic                                  bad_config
);

  localparam int KW = comb_enum_pkg::K_W;
  localparam int NW = comb_enum_pkg::N_W;
  localparam int VW = comb_enum_pkg::VAL_W;
  localparam int AW = (MAX_CHOSEN > 1) ? $clog2(MAX_CHOSEN) : 1;
  localparam int XW = (AW > KW) ? AW : KW;

  // Configuration and series state
  logic [NW-1:0] total_objects;
  logic [KW-1:0] chosen_count;
  logic          started;
  logic          exhausted;
  logic [KW-1:0] pick;        // rightmost position still below its maximum
  logic          pick_none;   // no such position: next request ends the series
  logic          maxed;       // pivot reached its maximum in this pass

  // Read side and emit stage
  logic [VW-1:0] mem [MAX_CHOSEN];
  logic [KW-1:0] pos;
  logic [VW-1:0] rd_data;
  logic          emit_v;
  logic [KW-1:0] emit_pos;
  logic [VW-1:0] prev;

  logic [NW-1:0] spare;
  logic [XW-1:0] rd_ext;
  logic [XW-1:0] wr_ext;
  logic [VW-1:0] value;
  logic          wr_en;
  logic          at_pick;
  logic          maxed_now;
  logic          emit_last;
  logic [KW-1:0] k_minus_one;
  logic          pick_none_next;
  logic [KW-1:0] pick_next;

  // Status toward the controller
  always_comb begin
    st.bad = ({2'b00, chosen_count} > total_objects) ||
             (int'(chosen_count) > MAX_CHOSEN) ||
             (int'(total_objects) > MAX_OBJECTS);
    st.series_done = (chosen_count == '0) || exhausted || (started && pick_none);
    st.issue_last  = (pos == k_minus_one);
  end

  assign spare       = total_objects - {2'b00, chosen_count};
  assign k_minus_one = chosen_count - 1'b1;
  assign rd_ext      = XW'(pos);
  assign wr_ext      = XW'(emit_pos);
  assign at_pick     = (emit_pos == pick);
  assign emit_last   = (emit_pos == k_minus_one);

  // Form the index at the emitted position
  always_comb begin
    if (!started) begin
      value = VW'(emit_pos);
      wr_en = emit_v;
    end else if (emit_pos < pick) begin
      value = rd_data;
      wr_en = 1'b0;
    end else if (at_pick) begin
      value = rd_data + 1'b1;
      wr_en = emit_v;
    end else begin
      value = prev + 1'b1;
      wr_en = emit_v;
    end
  end

  assign maxed_now = ({1'b0, value} == ((VW + 1)'(pick) + (VW + 1)'(spare)));

  // Pivot for the next request
  always_comb begin
    pick_next      = k_minus_one;
    pick_none_next = 1'b0;
    if (!started) begin
      pick_none_next = (spare == '0);
    end else if (at_pick ? maxed_now : maxed) begin
      pick_none_next = (pick == '0);
      pick_next      = pick - 1'b1;
    end
  end

  // Hold configuration and series state
  always_ff @(posedge clk) begin
    if (rst) begin
      total_objects <= comb_enum_pkg::RESET_TOTAL;
      chosen_count  <= comb_enum_pkg::RESET_CHOSEN;
      started       <= 1'b0;
      exhausted     <= 1'b0;
      pick          <= '0;
      pick_none     <= 1'b0;
      maxed         <= 1'b0;
    end else if (cfg_we) begin
      started   <= 1'b0;
      exhausted <= 1'b0;
      if (cfg_index == comb_enum_pkg::REG_TOTAL_OBJECTS) begin
        total_objects <= cfg_data;
      end else begin
        chosen_count <= cfg_data[KW-1:0];
      end
    end else begin
      if (cmd.report_fin) begin
        exhausted <= 1'b1;
      end
      if (emit_v && started && at_pick) begin
        maxed <= maxed_now;
      end
      if (emit_v && emit_last) begin
        started   <= 1'b1;
        pick      <= pick_next;
        pick_none <= pick_none_next;
      end
    end
  end

  // Advance the read position and feed the emit stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      emit_v <= 1'b0;
    end else begin
      emit_v <= cmd.issue;
      if (cmd.issue) begin
        pos <= st.issue_last ? '0 : pos + 1'b1;
      end
    end
  end

  // Choice memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= mem[rd_ext[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_ext[AW-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      emit_pos <= pos;
    end
    if (emit_v) begin
      prev <= value;
    end
  end

  // Drive the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit_v || cmd.report_bad || cmd.report_fin;
    end
    if (emit_v) begin
      element_value <= value[comb_enum_pkg::ELEM_W-1:0];
      position      <= emit_pos[comb_enum_pkg::POS_W-1:0];
      last_element  <= emit_last;
      finished      <= 1'b0;
      bad_config    <= 1'b0;
    end else begin
      element_value <= '0;
      position      <= '0;
      last_element  <= 1'b1;
      finished      <= cmd.report_fin;
      bad_config    <= cmd.report_bad;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/comb_enum_ctrl.sv
// Controller: sequences reports and the read pass of one request.
`default_nettype none

module comb_enum_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   advance,
  input  wire comb_enum_pkg::status_t st,
  output comb_enum_pkg::cmd_t         cmd,
  output logic                        busy
);

  typedef enum logic [1:0] {
    IDLE,
    REPORT,
    ISSUE,
    DRAIN
  } state_t;

  state_t state;

  // Hold state and registered commands
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      cmd   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (start && !busy && advance) begin
            busy <= 1'b1;
            if (st.bad) begin
              cmd.report_bad <= 1'b1;
              state          <= REPORT;
            end else if (st.series_done) begin
              cmd.report_fin <= 1'b1;
              state          <= REPORT;
            end else begin
              cmd.issue <= 1'b1;
              state     <= ISSUE;
            end
          end
        end
        REPORT: begin
          cmd   <= '0;
          busy  <= 1'b0;
          state <= IDLE;
        end
        ISSUE: begin
          if (st.issue_last) begin
            cmd.issue <= 1'b0;
            state     <= DRAIN;
          end
        end
        DRAIN: begin
          busy  <= 1'b0;
          state <= IDLE;
        end
        default: begin
          cmd   <= '0;
          busy  <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/combination_enumerator_core.sv
// Top level of the lexicographic k-combination enumerator.
//
//   channel   ports                                        handshake
//   request   start, advance, busy                         start && !busy
//   result    strobe, element_value, position,             strobe, one cycle,
//             last_element, finished, bad_config           no back-pressure
//   config    cfg_we, cfg_index, cfg_data                  cfg_we
//
// A request that yields a combination of k indexes keeps busy high through its k reads
// and the drain state; its k result words follow the accept through the command register,
// the emit stage and the result register, one a cycle. The pace is set by the single read port of the choice memory.
// A bad_config or finished request keeps busy high for one cycle and sends
// one word in the cycle after. Reset is synchronous; no clearing pass.
// Results cannot be stalled.
`default_nettype none

module combination_enumerator_core #(
  parameter int MAX_OBJECTS = comb_enum_pkg::DEF_MAX_OBJECTS,
  parameter int MAX_CHOSEN  = comb_enum_pkg::DEF_MAX_CHOSEN
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic                             advance,
  output logic                                  busy,
  input  wire logic                             cfg_we,
  input  wire logic [comb_enum_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [comb_enum_pkg::CFG_W-1:0]  cfg_data,
  output logic                                  strobe,
  output logic [comb_enum_pkg::ELEM_W-1:0]      element_value,
  output logic [comb_enum_pkg::POS_W-1:0]       position,
  output logic                                  last_element,
  output logic                                  finished,
  output logic                                  bad_config
);

  comb_enum_pkg::cmd_t    cmd;
  comb_enum_pkg::status_t st;

  comb_enum_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .advance (advance),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  comb_enum_dp #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .MAX_CHOSEN  (MAX_CHOSEN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .st            (st),
    .strobe        (strobe),
    .element_value (element_value),
    .position      (position),
    .last_element  (last_element),
    .finished      (finished),
    .bad_config    (bad_config)
  );

  // A report word is always the only word of its request
  assert property (@(posedge clk) disable iff (rst)
    strobe && (finished || bad_config) |-> last_element && element_value == '0 &&
      position == '0 && !(finished && bad_config))
    else $error("report word malformed");

  // Words of one combination come in consecutive cycles with rising position
  assert property (@(posedge clk) disable iff (rst)
    strobe && !finished && !bad_config && position != '0 |->
      $past(strobe) && !$past(last_element) &&
      position == $past(position) + 1'b1)
    else $error("combination word out of order");

  // An accepted request always raises busy
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && advance |=> busy)
    else $error("request accepted without going busy");

  // No result word without a pending request
  assert property (@(posedge clk) disable iff (rst)
    strobe && !$past(busy) |-> $past(strobe) || $past(busy, 2))
    else $error("result word with no request");

endmodule

`default_nettype wire

### tb/combination_enumerator_core_tb.sv
// Testbench for the combination enumerator: request driver, word monitor and predictor.
`default_nettype none

module combination_enumerator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OBJ       = comb_enum_pkg::DEF_MAX_OBJECTS;
  localparam int MAX_CHO       = comb_enum_pkg::DEF_MAX_CHOSEN;
  localparam int RANDOM_ITEMS  = 420;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int REPORT_LIMIT  = 10;

  // One result word as the block presents it
  typedef struct packed {
    logic [comb_enum_pkg::ELEM_W-1:0] elem;
    logic [comb_enum_pkg::POS_W-1:0]  pos;
    logic                             last;
    logic                             fin;
    logic                             bad;
  } enum_word_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             advance = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [comb_enum_pkg::IDX_W-1:0]  cfg_index = comb_enum_pkg::REG_TOTAL_OBJECTS;
  logic [comb_enum_pkg::CFG_W-1:0]  cfg_data = '0;
  logic                             busy;
  logic                             strobe;
  logic [comb_enum_pkg::ELEM_W-1:0] element_value;
  logic [comb_enum_pkg::POS_W-1:0]  position;
  logic                             last_element;
  logic                             finished;
  logic                             bad_config;

  combination_enumerator_core #(
    .MAX_OBJECTS(MAX_OBJ),
    .MAX_CHOSEN (MAX_CHO)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .advance      (advance),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .element_value(element_value),
    .position     (position),
    .last_element (last_element),
    .finished     (finished),
    .bad_config   (bad_config)
  );

  // Shared between stimulus, driver and monitor
  logic       request_queue[$];
  enum_word_t expected_words[$];
  logic       req_taken = 1'b0;
  bit         calm = 1'b0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  // Predictor state
  logic [comb_enum_pkg::N_W-1:0]   total_cfg;
  logic [comb_enum_pkg::K_W-1:0]   chosen_cfg;
  logic [comb_enum_pkg::VAL_W-1:0] choice_state[MAX_CHO];
  bit                              series_begun;
  bit                              series_over;

  initial begin
    forever #6 clk = ~clk;
  end

  // Append to the tail of the pending queues
  function automatic void queue_word(enum_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void queue_request(logic adv);
    request_queue.insert(request_queue.size(), adv);
  endfunction

  // Put the enumeration back to its first combination
  function automatic void restart_enumeration();
    for (int p = 0; p < MAX_CHO; p++) choice_state[p] = comb_enum_pkg::VAL_W'(p);
    series_begun = 1'b0;
    series_over  = 1'b0;
  endfunction

  function automatic void apply_register(logic [comb_enum_pkg::IDX_W-1:0] idx,
                                         logic [comb_enum_pkg::CFG_W-1:0] data);
    if (idx == comb_enum_pkg::REG_TOTAL_OBJECTS) begin
      total_cfg = data[comb_enum_pkg::N_W-1:0];
    end else begin
      chosen_cfg = data[comb_enum_pkg::K_W-1:0];
    end
    restart_enumeration();
  endfunction

  function automatic enum_word_t status_word(logic fin, logic bad);
    enum_word_t w;
    w = '0;
    w.last = 1'b1;
    w.fin  = fin;
    w.bad  = bad;
    return w;
  endfunction

  // Step to the next combination and queue the words it should produce
  function automatic void predict_combination(logic adv);
    int n;
    int k;
    int spare;
    int pick;
    bit found;
    enum_word_t w;
    n = int'(total_cfg);
    k = int'(chosen_cfg);
    if (!adv) return;
    if (k > n || k > MAX_CHO || n > MAX_OBJ) begin
      queue_word(status_word(1'b0, 1'b1));
      return;
    end
    if (k == 0) series_over = 1'b1;
    if (!series_over) begin
      spare = n - k;
      if (!series_begun) begin
        for (int p = 0; p < k; p++) choice_state[p] = comb_enum_pkg::VAL_W'(p);
        series_begun = 1'b1;
      end else begin
        found = 1'b0;
        pick  = 0;
        for (int p = k - 1; p >= 0; p--) begin
          if (!found && int'(choice_state[p]) < p + spare) begin
            pick  = p;
            found = 1'b1;
          end
        end
        if (found) begin
          choice_state[pick] = choice_state[pick] + 1'b1;
          for (int p = pick + 1; p < k; p++) choice_state[p] = choice_state[p-1] + 1'b1;
        end else begin
          series_over = 1'b1;
        end
      end
    end
    if (series_over) begin
      queue_word(status_word(1'b1, 1'b0));
      return;
    end
    for (int p = 0; p < k; p++) begin
      w.elem = choice_state[p][comb_enum_pkg::ELEM_W-1:0];
      w.pos  = comb_enum_pkg::POS_W'(p);
      w.last = (p == k - 1);
      w.fin  = 1'b0;
      w.bad  = 1'b0;
      queue_word(w);
    end
  endfunction

  // Monitor: check words, track register writes and accepted requests
  always @(posedge clk) begin
    enum_word_t got;
    enum_word_t want;
    if (rst) begin
      total_cfg  = comb_enum_pkg::RESET_TOTAL;
      chosen_cfg = comb_enum_pkg::RESET_CHOSEN;
      restart_enumeration();
      expected_words.delete();
      req_taken <= 1'b0;
    end else begin
      if (strobe) begin
        got = '{elem: element_value, pos: position, last: last_element,
                fin: finished, bad: bad_config};
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected word elem=%0d pos=%0d last=%b fin=%b bad=%b",
                     $realtime, got.elem, got.pos, got.last, got.fin, got.bad);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"%0t: word mismatch exp elem=%0d pos=%0d last=%b fin=%b bad=%b,",
                        " got elem=%0d pos=%0d last=%b fin=%b bad=%b"},
                       $realtime, want.elem, want.pos, want.last, want.fin, want.bad,
                       got.elem, got.pos, got.last, got.fin, got.bad);
          end
        end
      end
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (start && !busy) predict_combination(advance);
      req_taken <= start && !busy;
    end
  end

  // Driver: hold a request until taken, then pull the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      advance <= 1'b0;
    end else if (!(start && !req_taken)) begin
      if (request_queue.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
        advance <= request_queue.pop_front();
        start   <= 1'b1;
      end else begin
        start   <= 1'b0;
        advance <= 1'($urandom);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("combination_enumerator_core verification failed");
      $finish;
    end
  end

  // Wait until every request is out and every word is back
  task automatic wait_quiet();
    while (request_queue.size() != 0 || start || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back, chosen_count with junk in the spare bits
  task automatic set_selection(int n, int k);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= comb_enum_pkg::REG_TOTAL_OBJECTS;
    cfg_data  <= comb_enum_pkg::CFG_W'(n);
    @(negedge clk);
    cfg_index <= comb_enum_pkg::REG_CHOSEN_COUNT;
    cfg_data  <= {2'($urandom_range(3)), comb_enum_pkg::K_W'(k)};
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic queue_advances(int count);
    for (int i = 0; i < count; i++) queue_request(1'b1);
  endtask

  // Stimulus
  initial begin
    int served;
    int n;
    int k;
    int len;
    int r;
    logic adv;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset selection of 4 choose 2 run to the end, plus a request with advance low, which yields no word
    queue_request(1'b0);
    queue_advances(7);
    wait_quiet();
    // Empty selection
    set_selection(4, 0);
    queue_advances(1);
    wait_quiet();
    // Chosen count above total
    set_selection(4, 5);
    queue_advances(1);
    wait_quiet();
    // Too many objects
    set_selection(65, 2);
    queue_advances(1);
    wait_quiet();
    // Both registers at their top
    set_selection(127, 31);
    queue_advances(1);
    wait_quiet();
    // Chosen count beyond the supported maximum
    set_selection(64, 17);
    queue_advances(1);
    wait_quiet();
    // Widest valid selection
    set_selection(64, 16);
    queue_advances(2);
    wait_quiet();
    // Nothing to choose from
    set_selection(0, 0);
    queue_advances(1);
    wait_quiet();

    // Random phases; the first one is a no-gap run from the start of 64 choose 16
    served = 0;
    calm   = 1'b1;
    while (served < RANDOM_ITEMS) begin
      if (calm) begin
        n   = MAX_OBJ;
        k   = MAX_CHO;
        len = 22;
      end else begin
        r = $urandom_range(99);
        if (r < 12) begin
          case ($urandom_range(2))
            0: begin
              n = $urandom_range(0, 15);
              k = $urandom_range(n + 1, 16);
            end
            1: begin
              n = $urandom_range(MAX_OBJ + 1, 127);
              k = $urandom_range(0, 16);
            end
            default: begin
              n = $urandom_range(0, 127);
              k = $urandom_range(MAX_CHO + 1, 31);
            end
          endcase
          len = $urandom_range(1, 4);
        end else begin
          k = $urandom_range(0, MAX_CHO);
          if ($urandom_range(1)) n = k + $urandom_range(0, 3);
          else n = $urandom_range(k, MAX_OBJ);
          len = $urandom_range(4, 40);
        end
      end
      set_selection(n, k);
      for (int i = 0; i < len; i++) begin
        adv = ($urandom_range(99) >= 8);
        queue_request(adv);
        served++;
      end
      wait_quiet();
      calm = 1'b0;
    end

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("combination_enumerator_core verification clean");
    end else begin
      $display("combination_enumerator_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
